@@ rtl/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// rct_pkg - shared types and codes of the range coverage table
// Command and status codes, field widths, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int CMD_W    = 3;
    localparam int LEVEL_W  = 11;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SAVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_OVER  = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic init_we;  // clearing pass: write zero, advance clear address
        logic load;     // capture the input beat
        logic exec;     // apply the captured command
        logic scan;     // walk the table for a check
        logic push;     // hand the result to the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;    // clearing pass at the last entry
        logic is_check;    // captured command is a check
        logic level_zero;  // table empty
        logic scan_done;   // check finished this cycle
    } dp_status_t;

endpackage

@@ rtl/range_coverage_table.sv @@
// ----------------------------------------------------------------------------
// range_coverage_table - stack of recorded address ranges with coverage check
//
// Input stream (s_*): one beat per command - clear, record a range, save the
// fill level, restore it to a mark, or check whether a query range is
// exactly covered by the recorded ranges. Output stream (m_*): one beat per
// command carrying covered, the fill level after the command and a status.
//
// Clear, record, save, restore, unknown codes and a check on an empty
// table go from execution straight to the result hand-off. A check walks
// the table newest first, one memory read a cycle through a four-stage
// overlap pipeline, and ends early on an exact cover or an overcount.
// One command is in work at a time.
//
// Reset: the fill level clears at once, then a clearing pass writes zero to
// every entry, one a cycle, with s_tready low.
// Stall: a finished result waits in the output register; the next command
// is still taken, and its result holds until m_tready frees the register.
// ----------------------------------------------------------------------------
module range_coverage_table
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] cmd, [34:3] base, [66:35] length, [77:67] mark
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] covered, [11:1] level, [13:12] status
    output logic [15:0] m_tdata
);

    ctrl_cmd_t           ctrl_cmd;
    dp_status_t          dp_stat;
    logic                out_free;
    logic                res_covered;
    logic [LEVEL_W-1:0]  res_level;
    logic [STATUS_W-1:0] res_status;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    rct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (dp_stat),
        .in_ready (s_tready),
        .cmd      (ctrl_cmd)
    );

    rct_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (ctrl_cmd),
        .in_cmd      (s_tdata[2:0]),
        .in_base     (s_tdata[34:3]),
        .in_length   (s_tdata[66:35]),
        .in_mark     (s_tdata[77:67]),
        .stat        (dp_stat),
        .res_covered (res_covered),
        .res_level   (res_level),
        .res_status  (res_status)
    );

    // hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl_cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.push) m_data_reg <= {2'b00, res_status, res_level, res_covered};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // execution follows in the cycle after a taken beat
    a_exec_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.exec |-> $past(s_tvalid && s_tready))
        else $error("command executed without a taken beat");

    // one command in work at a time
    a_single_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while a command is in work");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.push |-> (!m_tvalid || m_tready))
        else $error("result pushed over a pending result");

    // a check only finishes while scanning
    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.scan_done |-> ctrl_cmd.scan && !s_tready)
        else $error("scan finished outside a check");

endmodule

@@ rtl/rct_ctrl.sv @@
// ----------------------------------------------------------------------------
// rct_ctrl - controller of the range coverage table
// Sequences the clearing pass, command capture, execution, table scan and
// result hand-off.
// ----------------------------------------------------------------------------
module rct_ctrl
    import rct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       out_free,
    input  dp_status_t stat,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.is_check && !stat.level_zero) state_next = ST_SCAN;
                else state_next = ST_RESULT;
            end
            ST_SCAN: begin
                if (stat.scan_done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_we = 1'b1;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_RESULT: begin
                cmd.push = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/rct_dpath.sv @@
// ----------------------------------------------------------------------------
// rct_dpath - datapath of the range coverage table
// Fill level, range memory, command registers and the four-stage overlap
// pipeline that subtracts each entry's overlap from the remaining count.
// ----------------------------------------------------------------------------
module rct_dpath
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [FIELD_W-1:0]  in_base,
    input  logic [FIELD_W-1:0]  in_length,
    input  logic [LEVEL_W-1:0]  in_mark,
    output dp_status_t          stat,
    output logic                res_covered,
    output logic [LEVEL_W-1:0]  res_level,
    output logic [STATUS_W-1:0] res_status
);

    localparam int AW = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);

    // command registers
    logic [CMD_W-1:0]   cmd_reg;
    logic [AW-1:0]      qbase_reg;
    logic [AW-1:0]      qlen_reg;
    logic [AW:0]        qend_reg;
    logic [LEVEL_W-1:0] mark_reg;

    logic [LW-1:0]       fill_reg;
    logic [IW-1:0]       clr_cnt_reg;
    logic [LW-1:0]       iss_cnt_reg;
    logic                covered_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AW-1:0]       rem_reg;

    // range memory: {length, base}
    logic [2*AW-1:0] mem [TABLE_DEPTH];
    logic [2*AW-1:0] rd_data_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    logic [2*AW-1:0] mem_wd;
    logic            rd_en;
    logic [LW-1:0]   iss_dec;
    logic            full;
    logic            mark_ok;

    // pipeline
    logic          p1_valid_reg, p1_last_reg;
    logic          p2_valid_reg, p2_last_reg;
    logic          p3_valid_reg, p3_last_reg;
    logic [AW-1:0] p2_start_reg;
    logic [AW:0]   p2_end_reg;
    logic [AW-1:0] p3_ov_reg;

    logic [AW-1:0] ov_lo;
    logic [AW:0]   ov_hi;
    logic [AW:0]   ov_diff;
    logic          ov_gt;
    logic [AW-1:0] rem_sub;
    logic          done;

    assign full    = (fill_reg == LW'(TABLE_DEPTH));
    assign mark_ok = (32'(mark_reg) < 32'(TABLE_DEPTH));
    assign iss_dec = iss_cnt_reg - LW'(1);
    assign rd_en   = cmd.scan && (iss_cnt_reg != '0);

    assign mem_we = cmd.init_we || (cmd.exec && (cmd_reg == CMD_RECORD) && !full);
    assign mem_wa = cmd.init_we ? clr_cnt_reg : fill_reg[IW-1:0];
    assign mem_wd = cmd.init_we ? '0 : {qlen_reg, qbase_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (rd_en) rd_data_reg <= mem[iss_dec[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_cmd;
            qbase_reg <= in_base[AW-1:0];
            qlen_reg  <= in_length[AW-1:0];
            qend_reg  <= {1'b0, in_base[AW-1:0]} + {1'b0, in_length[AW-1:0]};
            mark_reg  <= in_mark;
        end
    end

    // stage 3 overlap and stage 4 remainder update
    assign ov_lo   = (p2_start_reg > qbase_reg) ? p2_start_reg : qbase_reg;
    assign ov_hi   = (p2_end_reg < qend_reg) ? p2_end_reg : qend_reg;
    assign ov_diff = ov_hi - {1'b0, ov_lo};
    assign ov_gt   = (p3_ov_reg > rem_reg);
    assign rem_sub = rem_reg - p3_ov_reg;
    assign done    = cmd.scan && p3_valid_reg && (ov_gt || (rem_sub == '0) || p3_last_reg);

    always_ff @(posedge aclk) begin
        p2_start_reg <= rd_data_reg[AW-1:0];
        p2_end_reg   <= {1'b0, rd_data_reg[AW-1:0]} + {1'b0, rd_data_reg[2*AW-1:AW]};
        p3_ov_reg    <= ({1'b0, ov_lo} < ov_hi) ? ov_diff[AW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            clr_cnt_reg  <= '0;
            iss_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            p2_last_reg  <= 1'b0;
            p3_last_reg  <= 1'b0;
            covered_reg  <= 1'b0;
            status_reg   <= STS_OK;
            rem_reg      <= '0;
        end else begin
            if (cmd.init_we) clr_cnt_reg <= clr_cnt_reg + IW'(1);
            if (cmd.exec) begin
                covered_reg <= 1'b0;
                status_reg  <= STS_OK;
                rem_reg     <= qlen_reg;
                unique case (cmd_reg)
                    CMD_CLEAR: fill_reg <= '0;
                    CMD_RECORD: begin
                        if (full) status_reg <= STS_FULL;
                        else fill_reg <= fill_reg + LW'(1);
                    end
                    CMD_RESTORE: begin
                        if (mark_ok) fill_reg <= LW'(mark_reg);
                        else status_reg <= STS_RANGE;
                    end
                    CMD_CHECK: iss_cnt_reg <= fill_reg;
                    default: fill_reg <= fill_reg;
                endcase
            end
            if (done) begin
                // drop entries still in flight
                iss_cnt_reg  <= '0;
                p1_valid_reg <= 1'b0;
                p2_valid_reg <= 1'b0;
                p3_valid_reg <= 1'b0;
                if (ov_gt) status_reg <= STS_OVER;
                else if (rem_sub == '0) covered_reg <= 1'b1;
            end else begin
                if (rd_en) iss_cnt_reg <= iss_dec;
                p1_valid_reg <= rd_en;
                p1_last_reg  <= (iss_cnt_reg == LW'(1));
                p2_valid_reg <= p1_valid_reg;
                p2_last_reg  <= p1_last_reg;
                p3_valid_reg <= p2_valid_reg;
                p3_last_reg  <= p2_last_reg;
                if (cmd.scan && p3_valid_reg) rem_reg <= rem_sub;
            end
        end
    end

    assign stat.clr_last   = (clr_cnt_reg == IW'(TABLE_DEPTH - 1));
    assign stat.is_check   = (cmd_reg == CMD_CHECK);
    assign stat.level_zero = (fill_reg == '0);
    assign stat.scan_done  = done;

    assign res_covered = covered_reg;
    assign res_level   = LEVEL_W'(fill_reg);
    assign res_status  = status_reg;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - self-checking bench for range_coverage_table
// Sends command beats on the s_ stream and checks every m_ beat against a
// local model of the table or a hand-written result. The model holds the
// fill level and the newest-first coverage scan. A short directed table
// covers reset, the extremes of each field and the error codes. Random
// tiling sequences follow: query ranges cut into recorded pieces, some with
// gaps, overlaps or duplicates. Sender gaps and receiver stalls change in
// phases, and there is one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module testbench;
    import rct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 1024;
    localparam int RANDOM_BEATS   = 520;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 200;
    localparam int TAIL_CYCLES    = 16;

    // codes the block does not know; they must leave the table untouched
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    typedef struct packed {
        logic               covered;
        logic [LEVEL_W-1:0] level;
        logic [STATUS_W-1:0] status;
    } table_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [31:0]        base;
        logic [31:0]        len;
        logic [LEVEL_W-1:0] mark;
        logic               typed;
        table_result_t      want;
    } directed_row_t;

    // Directed beats. Rows with typed set carry a hand-written result; the
    // others are checked against the model.
    localparam int DIRECTED_COUNT = 23;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // fresh out of reset: empty table
        '{CMD_SAVE,    32'h0000_0000, 32'h0000_0000, 11'd0,    1'b1, '{1'b0, 11'd0, STS_OK}},
        '{CMD_CHECK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0,    1'b1, '{1'b0, 11'd0, STS_OK}},
        // restore marks at and beyond capacity are refused
        '{CMD_RESTORE, 32'h0000_0000, 32'h0000_0000, 11'd1024, 1'b1, '{1'b0, 11'd0, STS_RANGE}},
        '{CMD_RESTORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, '{1'b0, 11'd0, STS_RANGE}},
        // unknown codes change nothing
        '{CMD_SPARE_A, 32'h1234_5678, 32'h0000_0010, 11'd5,    1'b1, '{1'b0, 11'd0, STS_OK}},
        '{CMD_SPARE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, '{1'b0, 11'd0, STS_OK}},
        '{CMD_SPARE_C, 32'h0000_0000, 32'h0000_0000, 11'd0,    1'b1, '{1'b0, 11'd0, STS_OK}},
        // widest range from address zero
        '{CMD_RECORD,  32'h0000_0000, 32'hFFFF_FFFF, 11'd0,    1'b1, '{1'b0, 11'd1, STS_OK}},
        // zero-length and widest query on a non-empty table
        '{CMD_CHECK,   32'h0000_0000, 32'h0000_0000, 11'd0,    1'b1, '{1'b1, 11'd1, STS_OK}},
        '{CMD_CHECK,   32'h0000_0000, 32'hFFFF_FFFF, 11'd0,    1'b1, '{1'b1, 11'd1, STS_OK}},
        // range whose end runs past the top of the address space
        '{CMD_RECORD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0,    1'b1, '{1'b0, 11'd2, STS_OK}},
        '{CMD_CHECK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0,    1'b0, '{1'b0, 11'd0, STS_OK}},
        '{CMD_CHECK,   32'h0000_0000, 32'h0000_000A, 11'd0,    1'b0, '{1'b0, 11'd0, STS_OK}},
        // overlapping entries add up past the query length
        '{CMD_RECORD,  32'h0000_0000, 32'h0000_0008, 11'd0,    1'b1, '{1'b0, 11'd3, STS_OK}},
        '{CMD_CHECK,   32'h0000_0000, 32'h0000_000A, 11'd0,    1'b1, '{1'b0, 11'd3, STS_OVER}},
        '{CMD_SAVE,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, '{1'b0, 11'd3, STS_OK}},
        // restore above the level, then fill the table to the brim
        '{CMD_RESTORE, 32'h0000_0000, 32'h0000_0000, 11'd1023, 1'b1, '{1'b0, 11'd1023, STS_OK}},
        '{CMD_RECORD,  32'h8000_0000, 32'h8000_0000, 11'd0,    1'b1, '{1'b0, 11'd1024, STS_OK}},
        '{CMD_RECORD,  32'h0000_1000, 32'h0000_0100, 11'd0,    1'b1, '{1'b0, 11'd1024, STS_FULL}},
        // full-depth scan
        '{CMD_CHECK,   32'h0000_0000, 32'h0000_0064, 11'd0,    1'b0, '{1'b0, 11'd0, STS_OK}},
        '{CMD_RESTORE, 32'h0000_0000, 32'h0000_0000, 11'd1,    1'b1, '{1'b0, 11'd1, STS_OK}},
        '{CMD_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, '{1'b0, 11'd0, STS_OK}},
        '{CMD_CHECK,   32'h0000_0000, 32'h0000_0010, 11'd0,    1'b1, '{1'b0, 11'd0, STS_OK}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] cmd, [34:3] base, [66:35] length, [77:67] mark
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [0] covered, [11:1] level, [13:12] status
    logic [15:0] m_tdata;

    range_coverage_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Model of the table: recorded ranges and the fill level.
    logic [31:0]   model_base [DEPTH];
    logic [31:0]   model_size [DEPTH];
    int unsigned   model_level;

    table_result_t pending_results [$];
    table_result_t want;
    int unsigned   mismatch_count;
    int unsigned   beats_sent;
    int unsigned   sender_idle_pct;
    int unsigned   receiver_stall_pct;
    int unsigned   hold_left;
    bit            hold_request;
    int unsigned   idle_cycles;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Bytes shared by [s1, s1+l1) and [s2, s2+l2); ends are 33 bits so
    // ranges past the top of the address space do not wrap.
    function automatic logic [32:0] shared_bytes(input logic [31:0] s1, input logic [31:0] l1,
                                                 input logic [31:0] s2, input logic [31:0] l2);
        logic [32:0] end1;
        logic [32:0] end2;
        logic [32:0] lo;
        logic [32:0] hi;
        end1 = {1'b0, s1} + {1'b0, l1};
        end2 = {1'b0, s2} + {1'b0, l2};
        lo   = (s1 > s2) ? {1'b0, s1} : {1'b0, s2};
        hi   = (end2 < end1) ? end2 : end1;
        if (lo >= hi)
            return '0;
        return hi - lo;
    endfunction

    // Apply one command to the model table and return its result beat.
    function automatic table_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [31:0] base,
                                                    input logic [31:0] len,
                                                    input logic [LEVEL_W-1:0] mark);
        table_result_t res;
        logic [32:0]   remaining;
        logic [32:0]   ov;
        int unsigned   idx;
        bit            done;
        res = '0;
        case (cmd)
            CMD_CLEAR: begin
                model_level = 0;
            end
            CMD_RECORD: begin
                if (model_level >= DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    model_base[model_level] = base;
                    model_size[model_level] = len;
                    model_level++;
                end
            end
            CMD_RESTORE: begin
                if (mark < DEPTH)
                    model_level = mark;
                else
                    res.status = STS_RANGE;
            end
            CMD_CHECK: begin
                // walk newest first, stop on exact cover or overcount
                remaining = {1'b0, len};
                idx       = model_level;
                done      = (model_level == 0);
                while (idx > 0 && !done) begin
                    idx--;
                    ov = shared_bytes(model_base[idx], model_size[idx], base, len);
                    if (ov > remaining) begin
                        res.status = STS_OVER;
                        done       = 1'b1;
                    end else begin
                        remaining = remaining - ov;
                        if (remaining == 0) begin
                            res.covered = 1'b1;
                            done        = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.level = LEVEL_W'(model_level);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, exp);
        mismatch_count++;
    endtask

    // Compare every result beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'(m_tdata), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.covered)
                    report_mismatch("covered", 32'(m_tdata[0]), 32'(want.covered));
                if (m_tdata[11:1] !== want.level)
                    report_mismatch("level", 32'(m_tdata[11:1]), 32'(want.level));
                if (m_tdata[13:12] !== want.status)
                    report_mismatch("status", 32'(m_tdata[13:12]), 32'(want.status));
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    // The limit covers the clearing pass, a full-depth scan and the long hold.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Pick the idling pattern from the beat count, so that the phases take
    // turns, changing every 50 beats sent.
    task automatic set_idle_phase();
        case ((beats_sent / 50) % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
            default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
        endcase
    endtask

    // Offer one beat and hold it until taken; then log what must come back.
    // tvalid stays high afterwards, so the caller either offers again or
    // drops it through wait_for_results.
    task automatic offer_beat(input logic [CMD_W-1:0] cmd, input logic [31:0] base,
                              input logic [31:0] len, input logic [LEVEL_W-1:0] mark,
                              input logic typed, input table_result_t typed_result);
        table_result_t predicted;
        set_idle_phase();
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, mark, len, base, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = apply_command(cmd, base, len, mark);
        pending_results.push_back(typed ? typed_result : predicted);
        beats_sent++;
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [31:0] base,
                        input logic [31:0] len, input logic [LEVEL_W-1:0] mark);
        offer_beat(cmd, base, len, mark, 1'b0, '0);
    endtask

    // Drop tvalid straight after the last accepted beat and wait for the
    // block to hand back everything still owed.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
    endtask

    // Any command, any field values.
    task automatic send_noise();
        send(CMD_W'($urandom_range(0, 7)), $urandom(), $urandom(),
             LEVEL_W'($urandom_range(0, 2047)));
    endtask

    // Cut a query range into pieces, record them in random order, then check
    // it. A flaw may drop, stretch, shrink or repeat one piece, which can turn
    // the answer into not covered or overcount.
    task automatic run_tiling_sequence();
        logic [31:0] piece_len [8];
        logic [31:0] offsets [8];
        int unsigned order [8];
        logic [31:0] query_base;
        logic [31:0] query_len;
        logic [31:0] scale;
        logic [31:0] this_len;
        int unsigned pieces;
        int unsigned flaw;
        int unsigned j;
        int unsigned k;
        int unsigned swap;
        int unsigned pick;

        // start from an empty table or a shallow restore point
        if ($urandom_range(2) == 0)
            send(CMD_CLEAR, $urandom(), $urandom(), LEVEL_W'($urandom_range(0, 2047)));
        else
            send(CMD_RESTORE, $urandom(), $urandom(), LEVEL_W'($urandom_range(0, 8)));

        pieces = $urandom_range(1, 6);
        case ($urandom_range(2))
            0:       scale = 32'd16;
            1:       scale = 32'd4096;
            default: scale = 32'hFFFF_FFFF / pieces;
        endcase
        query_len = '0;
        for (j = 0; j < pieces; j++) begin
            piece_len[j] = $urandom_range(1, scale);
            offsets[j]   = query_len;
            query_len    = query_len + piece_len[j];
            order[j]     = j;
        end
        // near the top, so that ends cross the address space boundary
        if ($urandom_range(3) == 0)
            query_base = 32'hFFFF_FFFF - $urandom_range(0, 64);
        else
            query_base = $urandom();

        for (j = pieces - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            swap     = order[j];
            order[j] = order[k];
            order[k] = swap;
        end

        flaw = $urandom_range(0, 7);
        for (j = 0; j < pieces; j++) begin
            this_len = piece_len[order[j]];
            if (j == 0 && flaw == 1)
                this_len = this_len + $urandom_range(1, 8);
            if (j == 0 && flaw == 3 && this_len > 1)
                this_len = this_len - 1;
            if (!(j == 0 && flaw == 0 && pieces > 1)) begin
                send(CMD_RECORD, query_base + offsets[order[j]], this_len,
                     LEVEL_W'($urandom_range(0, 2047)));
                if (j == 0 && flaw == 2)
                    send(CMD_RECORD, query_base + offsets[order[j]], this_len,
                         LEVEL_W'($urandom_range(0, 2047)));
            end
            // unrelated range in between now and then
            if ($urandom_range(4) == 0)
                send(CMD_RECORD, $urandom(), $urandom_range(0, 256),
                     LEVEL_W'($urandom_range(0, 2047)));
        end

        if ($urandom_range(1) == 0)
            send(CMD_SAVE, $urandom(), $urandom(), LEVEL_W'($urandom_range(0, 2047)));
        send(CMD_CHECK, query_base, query_len, LEVEL_W'($urandom_range(0, 2047)));
        if ($urandom_range(3) == 0) begin
            pick = $urandom_range(0, pieces - 1);
            send(CMD_CHECK, query_base + offsets[pick], piece_len[pick],
                 LEVEL_W'($urandom_range(0, 2047)));
        end
        if ($urandom_range(5) == 0)
            send(CMD_CHECK, $urandom(), 32'd0, LEVEL_W'($urandom_range(0, 2047)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit hold_done;
        bit pause_done;
        int i;

        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        hold_request       = 1'b0;
        hold_done          = 1'b0;
        pause_done         = 1'b0;
        mismatch_count     = 0;
        beats_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        model_level        = 0;
        for (i = 0; i < DEPTH; i++) begin
            model_base[i] = '0;
            model_size[i] = '0;
        end

        // hold reset, then release on a falling edge; the clearing pass
        // shows as s_tready low and the first beat simply waits it out
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIRECTED_COUNT; i++)
            offer_beat(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].len,
                       DIRECTED_ROWS[i].mark, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        while (beats_sent < RANDOM_BEATS) begin
            // long output hold-off while beats keep coming: fill the block
            if (!hold_done && beats_sent >= 200) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            // sender pause until the block has handed back everything
            if (!pause_done && beats_sent >= 350) begin
                wait_for_results();
                pause_done = 1'b1;
            end
            if ($urandom_range(5) == 0)
                send_noise();
            else
                run_tiling_sequence();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ range_coverage_table.f @@
rtl/rct_pkg.sv
rtl/rct_ctrl.sv
rtl/rct_dpath.sv
rtl/range_coverage_table.sv
sim/testbench.sv
